[rtl/logistic_regression_minibatch_sgd_core_defines.svh]
// Assertion macros for the logistic-regression trainer.
`ifndef LOGISTIC_REGRESSION_MINIBATCH_SGD_CORE_DEFINES_SVH
`define LOGISTIC_REGRESSION_MINIBATCH_SGD_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LRSGD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define LRSGD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define LRSGD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LRSGD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/lrsgd_pkg.sv]
// Constants, types and the sigmoid table of the logistic-regression trainer.
package lrsgd_pkg;

  localparam int MAX_FEATURES    = 64;
  localparam int FIDX_W          = 6;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int SIG_W           = $clog2(SIGMOID_ENTRIES);

  localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [1:0] REG_BATCH_LEN    = 2'd1;
  localparam logic [1:0] REG_NUM_FEATURES = 2'd2;

  typedef logic [15:0] sig_table_t [SIGMOID_ENTRIES];

  // Builds the table at elaboration: e^-t by a short series on t/256, squared
  // eight times, then a rounded long division for 1 / (1 + e^-t).
  function automatic sig_table_t build_sigmoid();
    sig_table_t tab;
    longint unsigned d, t, u, u2, u3, u4, e, den, num, q, r, s, nn, ii;
    int k, b, i;
    bit neg;
    nn = longint'(SIGMOID_ENTRIES);
    for (i = 0; i < SIGMOID_ENTRIES; i++) begin
      ii  = longint'(i);
      neg = (2 * ii) < nn;
      d   = neg ? (nn - 2 * ii) : (2 * ii - nn);
      t   = (d << 33) / SIGMOID_ENTRIES;
      u   = t >> 8;
      u2  = (u * u) >> 30;
      u3  = (u2 * u) >> 30;
      u4  = (u3 * u) >> 30;
      e   = (64'd1 << 30) + u2 / 2 + u4 / 24 - u - u3 / 6;
      for (k = 0; k < 8; k++) begin
        e = (e * e) >> 30;
      end
      den = (64'd1 << 30) + e;
      num = (64'd1 << 46) + (den >> 1);
      q = 0;
      r = 0;
      for (b = 63; b >= 0; b--) begin
        r = (r << 1) | ((num >> b) & 64'd1);
        if (r >= den) begin
          r = r - den;
          q = q | (64'd1 << b);
        end
      end
      s = q;
      if (neg) begin
        s = 64'd65536 - s;
      end
      if (s > 64'd65535) begin
        s = 64'd65535;
      end
      tab[i] = s[15:0];
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sigmoid();

endpackage

[rtl/lrsgd_in_if.sv]
// Sample channel: one feature per transfer with label and end-of-data flag.
interface lrsgd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] feature_value;
  logic               label;
  logic               end_of_data;

  modport source (output valid, feature_value, label, end_of_data, input ready);
  modport sink (input valid, feature_value, label, end_of_data, output ready);
endinterface

[rtl/lrsgd_out_if.sv]
// Weight channel: one updated weight per transfer.
interface lrsgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight_value;
  logic [5:0]         weight_index;
  logic               last_weight;

  modport source (output valid, weight_value, weight_index, last_weight, input ready);
  modport sink (input valid, weight_value, weight_index, last_weight, output ready);
endinterface

[rtl/logistic_regression_minibatch_sgd_core.sv]
// Channel    Dir  Modport  Payload
// sample_i   in   sink     feature_value Q8.8, label, end_of_data
// weight_o   out  source   weight_value Q16.16, weight_index, last_weight
// cfg_*      in   write    step size, batch length, feature count
//
// A feature is transferred with a weight-memory read, then multiplied before the next can enter.
// A completing feature adds the dot-product and lookup steps, then a gradient memory pass over all features.
// A batch end adds a read, multiply, 64-step serial divide and output per weight.
// Reset clears valid bits of the weight and gradient memories; no clearing pass.
// A stalled weight channel holds the update pass; one weight waits in the output register.
`include "logistic_regression_minibatch_sgd_core_defines.svh"

module logistic_regression_minibatch_sgd_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  lrsgd_in_if.sink    sample_i,
  lrsgd_out_if.source weight_o
);

  localparam int FW    = lrsgd_pkg::FIDX_W;
  localparam int NF    = lrsgd_pkg::MAX_FEATURES;
  localparam int SIG_W = lrsgd_pkg::SIG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DOT  = 4'd2;
  localparam logic [3:0] S_LOOK = 4'd3;
  localparam logic [3:0] S_GMUL = 4'd4;
  localparam logic [3:0] S_GWR  = 4'd5;
  localparam logic [3:0] S_URD  = 4'd6;
  localparam logic [3:0] S_UMUL = 4'd7;
  localparam logic [3:0] S_UDIV = 4'd8;
  localparam logic [3:0] S_UOUT = 4'd9;

  localparam logic signed [47:0] Z_HALF  = 48'sd524288;
  localparam logic signed [42:0] W_MAX   = 43'sd2147483647;
  localparam logic signed [42:0] W_MIN   = -43'sd2147483648;

  // Configuration.
  logic [15:0] lr_q;
  logic [7:0]  bs_q;
  logic [6:0]  nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 16'd655;
      bs_q <= 8'd100;
      nf_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lrsgd_pkg::REG_STEP_SIZE:    lr_q <= cfg_data_i;
        lrsgd_pkg::REG_BATCH_LEN:    bs_q <= cfg_data_i[7:0];
        lrsgd_pkg::REG_NUM_FEATURES: nf_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [6:0]    nf_eff;
  logic [FW-1:0] nf_last;
  logic [7:0]    bs_eff;

  assign nf_eff  = (nf_q == 7'd0) ? 7'd1 : ((nf_q > 7'(NF)) ? 7'(NF) : nf_q);
  assign nf_last = FW'(nf_eff - 7'd1);
  assign bs_eff  = (bs_q == 8'd0) ? 8'd1 : bs_q;

  // Control and datapath registers.
  logic [3:0]          state_q, state_d;
  logic [FW-1:0]       fcnt_q;
  logic [FW-1:0]       j_q;
  logic [7:0]          bc_q;
  logic                last_q, lbl_q, eod_q, bend_q;
  logic                acc_pend_q;
  logic signed [15:0]  x_q;
  logic signed [47:0]  prod_q;
  logic signed [47:0]  dot_q;
  logic signed [17:0]  err_q;
  logic signed [33:0]  gprod_q;
  logic                sign_q;
  logic [63:0]         div_q;
  logic [7:0]          rem_q;
  logic [5:0]          dcnt_q;
  logic                out_vld_q;
  logic signed [31:0]  out_w_q;
  logic [5:0]          out_idx_q;
  logic                out_last_q;

  logic in_fire, out_free, item_last, j_last;

  assign sample_i.ready = (state_q == S_IDLE);
  assign in_fire   = sample_i.valid && sample_i.ready;
  assign out_free  = !out_vld_q || weight_o.ready;
  assign item_last = ({1'b0, fcnt_q} + 7'd1) >= nf_eff;
  assign j_last    = (j_q == nf_last);

  // Memories: one write and one registered read per cycle each.
  logic signed [15:0] s_mem [NF];
  logic signed [31:0] w_mem [NF];
  logic signed [47:0] g_mem [NF];
  logic [NF-1:0]      wvld_q, gvld_q;

  logic               s_re, w_re, g_re, w_we, g_we, g_clr;
  logic [FW-1:0]      s_raddr, w_raddr, g_raddr;
  logic signed [15:0] s_rd_q;
  logic signed [31:0] w_rd_q, w_wdata;
  logic signed [47:0] g_rd_q, g_wdata;
  logic               w_rdv_q, g_rdv_q;
  logic signed [31:0] w_eff;
  logic signed [47:0] g_eff;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_mem[fcnt_q] <= sample_i.feature_value;
    end
    if (s_re) begin
      s_rd_q <= s_mem[s_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[j_q] <= w_wdata;
    end
    if (w_re) begin
      w_rd_q  <= w_mem[w_raddr];
      w_rdv_q <= wvld_q[w_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      g_mem[j_q] <= g_wdata;
    end
    if (g_re) begin
      g_rd_q  <= g_mem[g_raddr];
      g_rdv_q <= gvld_q[g_raddr];
    end
  end

  // An entry never written since reset reads as zero; a gradient entry also since the last batch end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= '0;
      gvld_q <= '0;
    end else begin
      if (w_we) begin
        wvld_q[j_q] <= 1'b1;
      end
      if (g_clr) begin
        gvld_q <= '0;
      end else if (g_we) begin
        gvld_q[j_q] <= 1'b1;
      end
    end
  end

  assign w_eff = w_rdv_q ? w_rd_q : '0;
  assign g_eff = g_rdv_q ? g_rd_q : '0;

  // Sigmoid index from the finished dot product.
  logic [19:0]              z_off;
  logic [20+SIG_W:0]        z_prod;
  logic [SIG_W-1:0]         sig_idx;
  logic [15:0]              sig_val;

  assign z_off  = 20'(dot_q + Z_HALF);
  assign z_prod = (21+SIG_W)'(z_off) * (21+SIG_W)'(lrsgd_pkg::SIGMOID_ENTRIES);
  always_comb begin
    if (dot_q < -Z_HALF) begin
      sig_idx = '0;
    end else if (dot_q >= Z_HALF) begin
      sig_idx = SIG_W'(lrsgd_pkg::SIGMOID_ENTRIES - 1);
    end else begin
      sig_idx = z_prod[20 +: SIG_W];
    end
  end
  assign sig_val = lrsgd_pkg::SIG_TABLE[sig_idx];

  // Update arithmetic.
  logic        g_neg;
  logic [47:0] g_abs;
  logic [63:0] mag;
  logic [8:0]  rem_sh;
  logic        rem_ge;
  logic [64:0] dm_sum;
  logic [40:0] dm;
  logic signed [42:0] w_ext, dm_s, w_new;

  assign g_neg  = g_eff[47];
  assign g_abs  = g_neg ? 48'(-g_eff) : 48'(g_eff);
  assign mag    = 64'(g_abs) * 64'(lr_q);
  assign rem_sh = {rem_q, div_q[63]};
  assign rem_ge = rem_sh >= {1'b0, bc_q};
  assign dm_sum = {1'b0, div_q} + 65'd8388608;
  assign dm     = dm_sum[64:24];
  assign w_ext  = 43'(w_eff);
  assign dm_s   = signed'({2'b00, dm});
  assign w_new  = sign_q ? (w_ext + dm_s) : (w_ext - dm_s);
  always_comb begin
    if (w_new > W_MAX) begin
      w_wdata = 32'h7fff_ffff;
    end else if (w_new < W_MIN) begin
      w_wdata = 32'h8000_0000;
    end else begin
      w_wdata = 32'(w_new);
    end
  end

  assign g_wdata = g_eff + 48'(gprod_q);

  // Memory port control.
  always_comb begin
    s_re    = 1'b0;
    w_re    = 1'b0;
    g_re    = 1'b0;
    s_raddr = j_q + FW'(1);
    w_raddr = j_q;
    g_raddr = j_q + FW'(1);
    w_we    = 1'b0;
    g_we    = 1'b0;
    g_clr   = 1'b0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          w_re    = 1'b1;
          w_raddr = fcnt_q;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = last_q ? S_DOT : S_IDLE;
      end
      S_DOT: begin
        state_d = S_LOOK;
      end
      S_LOOK: begin
        s_re    = 1'b1;
        g_re    = 1'b1;
        s_raddr = '0;
        g_raddr = '0;
        state_d = S_GMUL;
      end
      S_GMUL: begin
        state_d = S_GWR;
      end
      S_GWR: begin
        g_we = 1'b1;
        if (j_last) begin
          state_d = bend_q ? S_URD : S_IDLE;
        end else begin
          s_re    = 1'b1;
          g_re    = 1'b1;
          state_d = S_GMUL;
        end
      end
      S_URD: begin
        w_re    = 1'b1;
        g_re    = 1'b1;
        g_raddr = j_q;
        state_d = S_UMUL;
      end
      S_UMUL: begin
        state_d = S_UDIV;
      end
      S_UDIV: begin
        if (dcnt_q == 6'd63) begin
          state_d = S_UOUT;
        end
      end
      S_UOUT: begin
        if (out_free) begin
          w_we = 1'b1;
          if (j_last) begin
            g_clr   = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_URD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fcnt_q     <= '0;
      j_q        <= '0;
      bc_q       <= '0;
      acc_pend_q <= 1'b0;
      dot_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_pend_q <= (state_q == S_MUL);
      if (acc_pend_q) begin
        dot_q <= dot_q + (prod_q >>> 8);
      end else if (state_q == S_LOOK) begin
        dot_q <= '0;
      end
      if (in_fire) begin
        fcnt_q <= item_last ? '0 : fcnt_q + FW'(1);
      end
      case (state_q)
        S_LOOK: begin
          j_q  <= '0;
          bc_q <= bc_q + 8'd1;
        end
        S_GWR: begin
          j_q <= j_last ? '0 : j_q + FW'(1);
        end
        S_UOUT: begin
          if (out_free) begin
            j_q <= j_last ? '0 : j_q + FW'(1);
            if (j_last) begin
              bc_q <= '0;
            end
          end
        end
        default: ;
      endcase
      if (state_q == S_UOUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (weight_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= sample_i.feature_value;
      last_q <= item_last;
      lbl_q  <= sample_i.label;
      eod_q  <= sample_i.end_of_data;
    end
    if (state_q == S_MUL) begin
      prod_q <= x_q * w_eff;
    end
    if (state_q == S_LOOK) begin
      err_q  <= signed'({2'b00, sig_val}) - (lbl_q ? 18'sd65536 : 18'sd0);
      bend_q <= ((bc_q + 8'd1) >= bs_eff) || eod_q;
    end
    if (state_q == S_GMUL) begin
      gprod_q <= s_rd_q * err_q;
    end
    if (state_q == S_UMUL) begin
      sign_q <= g_neg;
      div_q  <= mag;
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (state_q == S_UDIV) begin
      rem_q  <= rem_ge ? 8'(rem_sh - {1'b0, bc_q}) : rem_sh[7:0];
      div_q  <= {div_q[62:0], rem_ge};
      dcnt_q <= dcnt_q + 6'd1;
    end
    if (state_q == S_UOUT && out_free) begin
      out_w_q    <= w_wdata;
      out_idx_q  <= 6'(j_q);
      out_last_q <= j_last;
    end
  end

  assign weight_o.valid        = out_vld_q;
  assign weight_o.weight_value = out_w_q;
  assign weight_o.weight_index = out_idx_q;
  assign weight_o.last_weight  = out_last_q;

  `LRSGD_ASSERT_IMP(a_last_idx, clk_i, rst_ni, weight_o.valid && weight_o.last_weight, weight_o.weight_index == 6'(nf_last))
  `LRSGD_ASSERT_IMP(a_div_rem, clk_i, rst_ni, state_q == S_UDIV, rem_q < bc_q)
  `LRSGD_ASSERT_IMP(a_dot_clear, clk_i, rst_ni, state_q == S_IDLE && fcnt_q == '0 && !acc_pend_q, dot_q == '0)
  `LRSGD_ASSERT_NXT(a_batch_clr, clk_i, rst_ni, state_q == S_UOUT && out_free && j_last, bc_q == 8'd0 && gvld_q == '0)

endmodule

[bench/lrsgd_in_if.sv]
// Testbench compile unit; the channel interfaces themselves come from the RTL folder.
`timescale 1ns / 100ps

[bench/logistic_regression_minibatch_sgd_core_tb.sv]
// Testbench for the logistic-regression trainer: directed and random samples checked by a predictor.
`timescale 1ns / 100ps
module logistic_regression_minibatch_sgd_core_tb;

  typedef struct {
    logic signed [31:0] value;
    logic [5:0]         index;
    logic               last;
  } weight_t;

  typedef struct {
    logic signed [15:0] feature;
    logic               label;
    logic               eod;
  } feat_t;

  // One directed row: a register write or a feature, with an optional typed-in weight.
  typedef struct {
    bit                 cfg;
    logic [1:0]         idx;
    logic [15:0]        data;
    logic               label;
    logic               eod;
    bit                 typed;
    logic signed [31:0] exp_val;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  lrsgd_in_if  sample_if ();
  lrsgd_out_if weight_if ();

  logistic_regression_minibatch_sgd_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if.sink),
    .weight_o   (weight_if.source)
  );

  // Predictor state.
  logic [15:0]        sig_rom [lrsgd_pkg::SIGMOID_ENTRIES];
  logic signed [15:0] feat_mem [lrsgd_pkg::MAX_FEATURES];
  logic signed [31:0] wgt_mem [lrsgd_pkg::MAX_FEATURES];
  logic signed [63:0] grad_mem [lrsgd_pkg::MAX_FEATURES];
  logic signed [63:0] dot_acc;
  int unsigned        feat_cnt;
  int unsigned        batch_cnt;
  logic [15:0]        lr_reg;
  logic [7:0]         bs_reg;
  logic [6:0]         nf_reg;

  weight_t expected_weights[$];
  bit      failed;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      hold_off;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] sigmoid_entry(int i);
    longint unsigned d, t, u, u2, u3, u4, e, den, s, n;
    bit neg;
    n = lrsgd_pkg::SIGMOID_ENTRIES;
    neg = (2 * i) < n;
    d = neg ? n - 2 * i : 2 * i - n;
    t = (d << 33) / n;
    u = t >> 8;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    e = (64'd1 << 30) + u2 / 2 + u4 / 24 - u - u3 / 6;
    for (int k = 0; k < 8; k++) e = (e * e) >> 30;
    den = (64'd1 << 30) + e;
    s = ((64'd1 << 46) + den / 2) / den;
    if (neg) s = 65536 - s;
    if (s > 65535) s = 65535;
    return s[15:0];
  endfunction

  function automatic int unsigned active_count();
    if (nf_reg == 0) return 1;
    if (nf_reg > lrsgd_pkg::MAX_FEATURES) return lrsgd_pkg::MAX_FEATURES;
    return nf_reg;
  endfunction

  function automatic void reset_trainer();
    for (int i = 0; i < lrsgd_pkg::SIGMOID_ENTRIES; i++) sig_rom[i] = sigmoid_entry(i);
    for (int j = 0; j < lrsgd_pkg::MAX_FEATURES; j++) begin
      feat_mem[j] = '0;
      wgt_mem[j] = '0;
      grad_mem[j] = '0;
    end
    dot_acc = '0;
    feat_cnt = 0;
    batch_cnt = 0;
    lr_reg = 16'd655;
    bs_reg = 8'd100;
    nf_reg = 7'd64;
  endfunction

  // Trains on one feature and queues the weights of a finished batch.
  function automatic void train_feature(feat_t f);
    int unsigned nf, bs, pos, cnt_idx;
    longint signed prod, err, g, w, z;
    longint unsigned mag, dm;
    weight_t r;
    nf = active_count();
    bs = (bs_reg == 0) ? 1 : bs_reg;
    pos = feat_cnt % lrsgd_pkg::MAX_FEATURES;
    feat_mem[pos] = f.feature;
    prod = longint'(f.feature) * longint'(wgt_mem[pos]);
    dot_acc += prod >>> 8;
    if (pos + 1 < nf) begin
      feat_cnt = pos + 1;
      return;
    end
    z = dot_acc;
    if (z < -(64'sd1 <<< 19)) cnt_idx = 0;
    else if (z >= (64'sd1 <<< 19)) cnt_idx = lrsgd_pkg::SIGMOID_ENTRIES - 1;
    else cnt_idx = 32'(((z + (64'sd1 <<< 19)) * lrsgd_pkg::SIGMOID_ENTRIES) >>> 20);
    err = longint'(sig_rom[cnt_idx]) - (f.label ? 65536 : 0);
    for (int j = 0; j < nf; j++) grad_mem[j] += longint'(feat_mem[j]) * err;
    dot_acc = 0;
    feat_cnt = 0;
    batch_cnt++;
    if (batch_cnt < bs && !f.eod) return;
    for (int j = 0; j < nf; j++) begin
      g = grad_mem[j];
      mag = longint'(g < 0 ? -g : g) * longint'(lr_reg);
      dm = (mag / batch_cnt + (64'd1 << 23)) >> 24;
      w = longint'(wgt_mem[j]) - (g < 0 ? -longint'(dm) : longint'(dm));
      if (w > 64'sd2147483647) w = 64'sd2147483647;
      if (w < -64'sd2147483648) w = -64'sd2147483648;
      wgt_mem[j] = w[31:0];
      r.value = w[31:0];
      r.index = j[5:0];
      r.last = (j + 1 == nf);
      expected_weights.push_back(r);
    end
    for (int j = 0; j < lrsgd_pkg::MAX_FEATURES; j++) grad_mem[j] = '0;
    batch_cnt = 0;
  endfunction

  // A write is a one-cycle strobe, and the strobe is low again before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lrsgd_pkg::REG_STEP_SIZE:    lr_reg = data;
      lrsgd_pkg::REG_BATCH_LEN:    bs_reg = data[7:0];
      lrsgd_pkg::REG_NUM_FEATURES: nf_reg = data[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_feature(feat_t f);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.feature_value <= f.feature;
    sample_if.label <= f.label;
    sample_if.end_of_data <= f.eod;
    do @(posedge clk_i); while (!sample_if.ready);
    train_feature(f);
  endtask

  // Drains pending weights, then lets the gradient pass finish before a register write.
  task automatic wait_idle();
    int guard;
    sample_if.valid <= 1'b0;
    guard = 0;
    while (expected_weights.size() != 0 && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  // Receiver side and result checking.
  initial begin
    weight_t exp_w;
    weight_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (weight_if.valid && weight_if.ready) begin
        if (expected_weights.size() == 0) begin
          $display("%0t: expected none, got weight idx %0d value %0d", $time,
                   weight_if.weight_index, weight_if.weight_value);
          failed = 1'b1;
        end else begin
          exp_w = expected_weights.pop_front();
          if (weight_if.weight_value !== exp_w.value || weight_if.weight_index !== exp_w.index ||
              weight_if.last_weight !== exp_w.last) begin
            $display("%0t: expected val %0d idx %0d last %0b, got val %0d idx %0d last %0b",
                     $time, exp_w.value, exp_w.index, exp_w.last, weight_if.weight_value,
                     weight_if.weight_index, weight_if.last_weight);
            failed = 1'b1;
          end
        end
      end
      weight_if.ready <= !hold_off &&
                         !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [15:0] data);
    dir_row_t r;
    r.cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    r.label = 1'b0;
    r.eod = 1'b0;
    r.typed = 1'b0;
    r.exp_val = '0;
    return r;
  endfunction

  function automatic dir_row_t feat_row(logic [15:0] data, logic label, logic eod);
    dir_row_t r;
    r.cfg = 1'b0;
    r.idx = lrsgd_pkg::REG_STEP_SIZE;
    r.data = data;
    r.label = label;
    r.eod = eod;
    r.typed = 1'b0;
    r.exp_val = '0;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [15:0] data, logic label, logic eod,
                                         logic signed [31:0] exp_val);
    dir_row_t r;
    r = feat_row(data, label, eod);
    r.typed = 1'b1;
    r.exp_val = exp_val;
    return r;
  endfunction

  dir_row_t directed [$];

  task automatic random_samples(int count);
    feat_t f;
    int nf;
    for (int s = 0; s < count; s++) begin
      nf = int'(active_count());
      for (int k = 0; k < nf; k++) begin
        case ($urandom_range(3))
          0: f.feature = 16'($urandom);
          1: f.feature = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          default: f.feature = $signed(16'($urandom_range(2047))) - 16'sd1024;
        endcase
        f.label = 1'($urandom_range(1));
        f.eod = (k + 1 == nf) ? ($urandom_range(9) == 0) : 1'($urandom_range(1));
        send_feature(f);
      end
    end
  endtask

  initial begin
    feat_t f;
    int phase;
    int n_before;
    failed = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = lrsgd_pkg::REG_STEP_SIZE;
    cfg_data_i = '0;
    sample_if.valid = 1'b0;
    sample_if.feature_value = '0;
    sample_if.label = 1'b0;
    sample_if.end_of_data = 1'b0;
    reset_trainer();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. A zero step size right after reset leaves the weight at zero.
    directed.push_back(cfg_row(lrsgd_pkg::REG_NUM_FEATURES, 16'd1));
    directed.push_back(cfg_row(lrsgd_pkg::REG_BATCH_LEN, 16'd1));
    directed.push_back(cfg_row(lrsgd_pkg::REG_STEP_SIZE, 16'd0));
    directed.push_back(typed_row(16'h7fff, 1'b1, 1'b0, 32'sd0));
    // Tiny samples, extreme features, both labels, end of data.
    directed.push_back(cfg_row(lrsgd_pkg::REG_NUM_FEATURES, 16'd2));
    directed.push_back(cfg_row(lrsgd_pkg::REG_BATCH_LEN, 16'd3));
    directed.push_back(cfg_row(lrsgd_pkg::REG_STEP_SIZE, 16'hffff));
    directed.push_back(feat_row(16'h7fff, 1'b1, 1'b0));
    directed.push_back(feat_row(16'h8000, 1'b1, 1'b0));
    directed.push_back(feat_row(16'h8000, 1'b0, 1'b1));
    directed.push_back(feat_row(16'h7fff, 1'b0, 1'b1));
    directed.push_back(feat_row(16'h0100, 1'b0, 1'b0));
    directed.push_back(feat_row(16'hff00, 1'b1, 1'b0));
    directed.push_back(feat_row(16'h0000, 1'b1, 1'b0));
    directed.push_back(feat_row(16'h0000, 1'b0, 1'b0));
    directed.push_back(feat_row(16'h7fff, 1'b1, 1'b0));
    directed.push_back(feat_row(16'h7fff, 1'b1, 1'b0));
    // Shrinking the feature count mid-sample ends the sample on the next feature.
    directed.push_back(feat_row(16'h1234, 1'b0, 1'b0));
    directed.push_back(cfg_row(lrsgd_pkg::REG_NUM_FEATURES, 16'd1));
    directed.push_back(cfg_row(lrsgd_pkg::REG_BATCH_LEN, 16'd0));
    directed.push_back(feat_row(16'h4000, 1'b1, 1'b0));
    directed.push_back(feat_row(16'hc000, 1'b0, 1'b0));
    directed.push_back(cfg_row(lrsgd_pkg::REG_NUM_FEATURES, 16'd0));
    directed.push_back(cfg_row(lrsgd_pkg::REG_STEP_SIZE, 16'd0));
    directed.push_back(feat_row(16'h7fff, 1'b1, 1'b1));
    directed.push_back(cfg_row(lrsgd_pkg::REG_NUM_FEATURES, 16'd127));
    directed.push_back(cfg_row(lrsgd_pkg::REG_BATCH_LEN, 16'd1));
    directed.push_back(cfg_row(lrsgd_pkg::REG_STEP_SIZE, 16'd65535));

    foreach (directed[i]) begin
      if (directed[i].cfg) begin
        wait_idle();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        f.feature = directed[i].data;
        f.label = directed[i].label;
        f.eod = directed[i].eod;
        n_before = expected_weights.size();
        send_feature(f);
        if (directed[i].typed) begin
          if (expected_weights.size() <= n_before) begin
            $display("%0t: expected weight %0d, got no update", $time, directed[i].exp_val);
            failed = 1'b1;
          end else begin
            expected_weights[n_before].value = directed[i].exp_val;
          end
        end
      end
    end
    // One full-width sample with the feature count clamped to the maximum.
    random_samples(1);
    wait_idle();

    // Random phases with varied settings and idling.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_reg(lrsgd_pkg::REG_NUM_FEATURES, 16'($urandom_range(2, 6)));
      write_reg(lrsgd_pkg::REG_BATCH_LEN, 16'($urandom_range(1, 4)));
      write_reg(lrsgd_pkg::REG_STEP_SIZE, 16'($urandom));
      random_samples(20);
      wait_idle();
    end

    // Receiver holds off while samples keep coming, so the block backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(lrsgd_pkg::REG_NUM_FEATURES, 16'd3);
    write_reg(lrsgd_pkg::REG_BATCH_LEN, 16'd1);
    write_reg(lrsgd_pkg::REG_STEP_SIZE, 16'd40000);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_samples(20);
    join
    wait_idle();

    if (expected_weights.size() != 0) begin
      $display("%0t: expected %0d more weights, got none", $time, expected_weights.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
